FILE: rtl/ppaa_pkg.sv
// Shared types, constants and lookup functions for the principal axis angle block.
package ppaa_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int COORD_BITS   = 16;
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int LOG_W        = $clog2(MAX_POINTS);
    localparam int SUM_W        = COORD_BITS + LOG_W;
    localparam int SQ_W         = 2 * COORD_BITS + LOG_W;
    localparam int MUL_W        = SUM_W + 1;
    localparam int ACC_W        = 2 * MUL_W;
    localparam int MAG_W        = ACC_W + 1;
    localparam int NORM_BITS    = 30;
    localparam int XY_W         = NORM_BITS + 4;
    localparam int CORDIC_STEPS = 17;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int Z_W          = 20;
    localparam int ANGLE_W      = 16;
    localparam int ANGLE_LIMIT  = 25736;
    localparam int HALF_PI      = 102944;
    localparam int MIN_VALID    = 3;

    localparam logic [CNT_W-1:0]        MAX_CNT     = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0]        MIN_CNT     = CNT_W'(MIN_VALID);
    localparam logic signed [Z_W-1:0]   HALF_PI_Z   = Z_W'(HALF_PI);
    localparam logic signed [Z_W-1:0]   ANG_MAX_Z   = Z_W'(ANGLE_LIMIT);
    localparam logic signed [Z_W-1:0]   ANG_MIN_Z   = Z_W'(-ANGLE_LIMIT);
    localparam logic signed [ANGLE_W-1:0] ANG_LIMIT_A = ANGLE_W'(ANGLE_LIMIT);

    typedef struct packed {
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_z;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] axis_angle;
        logic                      angle_valid;
        logic                      points_dropped;
    } result_t;

    // Target of one multiply micro-op
    typedef enum logic [2:0] {
        DST_XX,
        DST_XZ,
        DST_ZZ,
        DST_D,
        DST_C
    } dst_t;

    typedef struct packed {
        logic valid;
        dst_t dest;
        logic hi;
        logic sub;
    } mul_op_t;

    // Micro-op sequence: per-point products, then the covariance terms
    typedef enum logic [3:0] {
        OP_XX,
        OP_XZ,
        OP_ZZ,
        OP_NXX_LO,
        OP_NXX_HI,
        OP_SXX,
        OP_NZZ_LO,
        OP_NZZ_HI,
        OP_SZZ,
        OP_NXZ_LO,
        OP_NXZ_HI,
        OP_SXZ
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_ASTART,
        ST_ANGLE,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        ANG_IDLE,
        ANG_NORM,
        ANG_ROT,
        ANG_FINISH
    } ang_state_t;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } ang_res_t;

    // Arctangent of 2^-i in units of 2^-16 rad
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = Z_W'(51472);
            5'd1:    v = Z_W'(30385);
            5'd2:    v = Z_W'(16055);
            5'd3:    v = Z_W'(8150);
            5'd4:    v = Z_W'(4091);
            5'd5:    v = Z_W'(2047);
            5'd6:    v = Z_W'(1024);
            5'd7:    v = Z_W'(512);
            5'd8:    v = Z_W'(256);
            5'd9:    v = Z_W'(128);
            5'd10:   v = Z_W'(64);
            5'd11:   v = Z_W'(32);
            5'd12:   v = Z_W'(16);
            5'd13:   v = Z_W'(8);
            5'd14:   v = Z_W'(4);
            5'd15:   v = Z_W'(2);
            5'd16:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/planar_principal_axis_angle_top.sv
// Principal axis angle of a point cluster in the x-z plane: sequencer, sums and result register.
//
// Points arrive one per transfer; the block sums x, z, x*x, x*z and z*z and, on the point
// flagged last, forms the n^2-scaled covariance and reports the major-axis angle modulo pi
// (radians * 16384, -25736..25736), with angle_valid low for fewer than three points and
// points_dropped high if points past the 1024-point bound were ignored. All products run
// through one shared 27x27 multiplier: an accepted point takes three products plus pipeline
// drain before point_ready returns, and a point past the bound is dropped with no products.
// A last point then adds the covariance products and drain, a start state, normalizing shifts
// that bring max(|A-B|, 2|C|) below 2^30, 17 CORDIC rotations, a finish state and a result
// state; a covariance with no spread skips the shifts and rotations, and fewer than three
// points go straight from the drain to the result state. The result sits in an
// output register, so the next cluster's points are taken while it waits for result_ready;
// the result cycle stretches only while the previous result is still waiting.
module planar_principal_axis_angle_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  ppaa_pkg::point_t  point,
    output logic              result_valid,
    input  logic              result_ready,
    output ppaa_pkg::result_t result
);

    localparam int CB    = ppaa_pkg::COORD_BITS;
    localparam int SUM_W = ppaa_pkg::SUM_W;
    localparam int SQ_W  = ppaa_pkg::SQ_W;
    localparam int MUL_W = ppaa_pkg::MUL_W;
    localparam int ACC_W = ppaa_pkg::ACC_W;
    localparam int CNT_W = ppaa_pkg::CNT_W;

    ppaa_pkg::state_t  state_reg, state_next;
    ppaa_pkg::op_t     step_reg, step_next;
    logic              last_reg, last_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [CB-1:0]    px_reg, px_next, pz_reg, pz_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_z_reg, sum_z_next;
    logic signed [SQ_W-1:0]  sum_xx_reg, sum_xx_next, sum_xz_reg, sum_xz_next;
    logic signed [SQ_W-1:0]  sum_zz_reg, sum_zz_next;
    logic signed [ACC_W-1:0] acc_d_reg, acc_d_next, acc_c_reg, acc_c_next;
    logic              res_valid_reg, res_valid_next;
    ppaa_pkg::result_t res_reg, res_next;

    logic                    accept, fits, out_free, ang_start;
    ppaa_pkg::mul_op_t       mul_op, mul_q;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] prod_q, term, addend;
    logic signed [MUL_W-1:0] n_op, sx_op, sz_op, px_op, pz_op;
    logic signed [MUL_W-1:0] xx_lo, xz_lo, zz_lo;
    logic signed [CB-1:0]    xx_hi, xz_hi, zz_hi;
    ppaa_pkg::ang_res_t      ang;

    assign point_ready  = (state_reg == ppaa_pkg::ST_IDLE);
    assign accept       = point_valid && point_ready;
    assign fits         = (count_reg < ppaa_pkg::MAX_CNT);
    assign out_free     = !res_valid_reg || result_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Operand select for the shared multiplier
    always_comb
    begin
        n_op  = signed'({{(MUL_W-CNT_W){1'b0}}, count_reg});
        sx_op = MUL_W'(sum_x_reg);
        sz_op = MUL_W'(sum_z_reg);
        px_op = MUL_W'(px_reg);
        pz_op = MUL_W'(pz_reg);
        xx_lo = signed'({{(MUL_W-SUM_W){1'b0}}, sum_xx_reg[SUM_W-1:0]});
        xz_lo = signed'({{(MUL_W-SUM_W){1'b0}}, sum_xz_reg[SUM_W-1:0]});
        zz_lo = signed'({{(MUL_W-SUM_W){1'b0}}, sum_zz_reg[SUM_W-1:0]});
        xx_hi = sum_xx_reg[SQ_W-1:SUM_W];
        xz_hi = sum_xz_reg[SQ_W-1:SUM_W];
        zz_hi = sum_zz_reg[SQ_W-1:SUM_W];

        mul_a        = '0;
        mul_b        = '0;
        mul_op.valid = (state_reg == ppaa_pkg::ST_MUL);
        mul_op.dest  = ppaa_pkg::DST_D;
        mul_op.hi    = 1'b0;
        mul_op.sub   = 1'b0;

        unique case (step_reg)
            ppaa_pkg::OP_XX:
            begin
                mul_a = px_op; mul_b = px_op; mul_op.dest = ppaa_pkg::DST_XX;
            end
            ppaa_pkg::OP_XZ:
            begin
                mul_a = px_op; mul_b = pz_op; mul_op.dest = ppaa_pkg::DST_XZ;
            end
            ppaa_pkg::OP_ZZ:
            begin
                mul_a = pz_op; mul_b = pz_op; mul_op.dest = ppaa_pkg::DST_ZZ;
            end
            ppaa_pkg::OP_NXX_LO:
            begin
                mul_a = n_op; mul_b = xx_lo;
            end
            ppaa_pkg::OP_NXX_HI:
            begin
                mul_a = n_op; mul_b = MUL_W'(xx_hi); mul_op.hi = 1'b1;
            end
            ppaa_pkg::OP_SXX:
            begin
                mul_a = sx_op; mul_b = sx_op; mul_op.sub = 1'b1;
            end
            ppaa_pkg::OP_NZZ_LO:
            begin
                mul_a = n_op; mul_b = zz_lo; mul_op.sub = 1'b1;
            end
            ppaa_pkg::OP_NZZ_HI:
            begin
                mul_a = n_op; mul_b = MUL_W'(zz_hi); mul_op.hi = 1'b1; mul_op.sub = 1'b1;
            end
            ppaa_pkg::OP_SZZ:
            begin
                mul_a = sz_op; mul_b = sz_op;
            end
            ppaa_pkg::OP_NXZ_LO:
            begin
                mul_a = n_op; mul_b = xz_lo; mul_op.dest = ppaa_pkg::DST_C;
            end
            ppaa_pkg::OP_NXZ_HI:
            begin
                mul_a = n_op; mul_b = MUL_W'(xz_hi); mul_op.dest = ppaa_pkg::DST_C;
                mul_op.hi = 1'b1;
            end
            ppaa_pkg::OP_SXZ:
            begin
                mul_a = sx_op; mul_b = sz_op; mul_op.dest = ppaa_pkg::DST_C;
                mul_op.sub = 1'b1;
            end
            default:
            begin
                mul_op.valid = 1'b0;
            end
        endcase
    end

    ppaa_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mul_op),
        .a      (mul_a),
        .b      (mul_b),
        .op_q   (mul_q),
        .prod_q (prod_q)
    );

    ppaa_angle u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_start),
        .d     (acc_d_reg),
        .c     (acc_c_reg),
        .res   (ang)
    );

    always_comb
    begin
        term   = mul_q.hi ? {prod_q[ACC_W-SUM_W-1:0], {SUM_W{1'b0}}} : prod_q;
        addend = mul_q.sub ? -term : term;

        state_next     = state_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        count_next     = count_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        sum_x_next     = sum_x_reg;
        sum_z_next     = sum_z_reg;
        sum_xx_next    = sum_xx_reg;
        sum_xz_next    = sum_xz_reg;
        sum_zz_next    = sum_zz_reg;
        acc_d_next     = acc_d_reg;
        acc_c_next     = acc_c_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        ang_start      = 1'b0;

        // Retire the product issued last cycle
        if (mul_q.valid)
        begin
            case (mul_q.dest)
                ppaa_pkg::DST_XX: sum_xx_next = sum_xx_reg + addend[SQ_W-1:0];
                ppaa_pkg::DST_XZ: sum_xz_next = sum_xz_reg + addend[SQ_W-1:0];
                ppaa_pkg::DST_ZZ: sum_zz_next = sum_zz_reg + addend[SQ_W-1:0];
                ppaa_pkg::DST_D:  acc_d_next  = acc_d_reg + addend;
                ppaa_pkg::DST_C:  acc_c_next  = acc_c_reg + addend;
                default:          acc_d_next  = acc_d_reg;
            endcase
        end

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ppaa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = point.last_point;
                    if (fits)
                    begin
                        count_next = count_reg + 1'b1;
                        px_next    = point.coord_x[CB-1:0];
                        pz_next    = point.coord_z[CB-1:0];
                        sum_x_next = sum_x_reg + SUM_W'(signed'(point.coord_x[CB-1:0]));
                        sum_z_next = sum_z_reg + SUM_W'(signed'(point.coord_z[CB-1:0]));
                        step_next  = ppaa_pkg::OP_XX;
                        state_next = ppaa_pkg::ST_MUL;
                    end
                    else
                    begin
                        // Cluster full: drop the point, still close out on the last one
                        ovf_next = 1'b1;
                        if (point.last_point)
                        begin
                            acc_d_next = '0;
                            acc_c_next = '0;
                            step_next  = ppaa_pkg::OP_NXX_LO;
                            state_next = ppaa_pkg::ST_MUL;
                        end
                    end
                end
            end
            ppaa_pkg::ST_MUL:
            begin
                if (step_reg == ppaa_pkg::OP_ZZ || step_reg == ppaa_pkg::OP_SXZ)
                begin
                    state_next = ppaa_pkg::ST_DRAIN;
                end
                else
                begin
                    step_next = ppaa_pkg::op_t'(step_reg + 1'b1);
                end
            end
            ppaa_pkg::ST_DRAIN:
            begin
                if (step_reg == ppaa_pkg::OP_SXZ)
                begin
                    state_next = ppaa_pkg::ST_ASTART;
                end
                else if (last_reg)
                begin
                    if (count_reg >= ppaa_pkg::MIN_CNT)
                    begin
                        acc_d_next = '0;
                        acc_c_next = '0;
                        step_next  = ppaa_pkg::OP_NXX_LO;
                        state_next = ppaa_pkg::ST_MUL;
                    end
                    else
                    begin
                        state_next = ppaa_pkg::ST_RESULT;
                    end
                end
                else
                begin
                    state_next = ppaa_pkg::ST_IDLE;
                end
            end
            ppaa_pkg::ST_ASTART:
            begin
                ang_start  = 1'b1;
                state_next = ppaa_pkg::ST_ANGLE;
            end
            ppaa_pkg::ST_ANGLE:
            begin
                if (ang.done)
                begin
                    state_next = ppaa_pkg::ST_RESULT;
                end
            end
            ppaa_pkg::ST_RESULT:
            begin
                // Hold until the output register is free, then clear for the next cluster
                if (out_free)
                begin
                    res_valid_next          = 1'b1;
                    res_next.angle_valid    = (count_reg >= ppaa_pkg::MIN_CNT);
                    res_next.axis_angle     = (count_reg >= ppaa_pkg::MIN_CNT) ? ang.angle : '0;
                    res_next.points_dropped = ovf_reg;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    last_next   = 1'b0;
                    sum_x_next  = '0;
                    sum_z_next  = '0;
                    sum_xx_next = '0;
                    sum_xz_next = '0;
                    sum_zz_next = '0;
                    state_next  = ppaa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppaa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppaa_pkg::ST_IDLE;
            step_reg      <= ppaa_pkg::OP_XX;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_z_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_xz_reg    <= '0;
            sum_zz_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_z_reg     <= sum_z_next;
            sum_xx_reg    <= sum_xx_next;
            sum_xz_reg    <= sum_xz_next;
            sum_zz_reg    <= sum_zz_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        pz_reg    <= pz_next;
        acc_d_reg <= acc_d_next;
        acc_c_reg <= acc_c_next;
        res_reg   <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppaa_pkg::MAX_CNT)
        else $error("point count past bound");

    a_mul_issue: assert property (@(posedge clk) disable iff (!rst_n)
        mul_q.valid |-> $past(state_reg == ppaa_pkg::ST_MUL))
        else $error("product retired without an issue");

    a_angle_done: assert property (@(posedge clk) disable iff (!rst_n)
        ang.done |-> state_reg == ppaa_pkg::ST_ANGLE)
        else $error("angle unit finished while not awaited");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.angle_valid) |-> res_reg.axis_angle == '0)
        else $error("nonzero angle on a short cluster");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.axis_angle <= ppaa_pkg::ANG_LIMIT_A
                           && res_reg.axis_angle >= -ppaa_pkg::ANG_LIMIT_A))
        else $error("angle outside limit");

endmodule

FILE: rtl/ppaa_mul.sv
// Shared signed multiplier with registered product and micro-op tag.
module ppaa_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ppaa_pkg::mul_op_t                      op,
    input  logic signed [ppaa_pkg::MUL_W-1:0]      a,
    input  logic signed [ppaa_pkg::MUL_W-1:0]      b,
    output ppaa_pkg::mul_op_t                      op_q,
    output logic signed [ppaa_pkg::ACC_W-1:0]      prod_q
);

    ppaa_pkg::mul_op_t                 op_reg;
    logic signed [ppaa_pkg::ACC_W-1:0] prod_reg;
    logic signed [ppaa_pkg::ACC_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= ppaa_pkg::mul_op_t'('0);
        end
        else
        begin
            op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign op_q   = op_reg;
    assign prod_q = prod_reg;

endmodule

FILE: rtl/ppaa_angle.sv
// Normalizer and iterative vectoring CORDIC giving the halved atan2 of the covariance terms.
module ppaa_angle (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [ppaa_pkg::ACC_W-1:0] d,
    input  logic signed [ppaa_pkg::ACC_W-1:0] c,
    output ppaa_pkg::ang_res_t                res
);

    localparam int MAG_W = ppaa_pkg::MAG_W;
    localparam int XY_W  = ppaa_pkg::XY_W;
    localparam int Z_W   = ppaa_pkg::Z_W;
    localparam int NB    = ppaa_pkg::NORM_BITS;

    ppaa_pkg::ang_state_t st_reg, st_next;
    logic [MAG_W-1:0]                     mx_reg, mx_next, my_reg, my_next;
    logic                                 dneg_reg, dneg_next, cneg_reg, cneg_next;
    logic signed [XY_W-1:0]               x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]                z_reg, z_next;
    logic [ppaa_pkg::ITER_W-1:0]          it_reg, it_next;
    logic signed [ppaa_pkg::ANGLE_W-1:0]  angle_reg, angle_next;

    logic signed [MAG_W-1:0] d_ext, c_ext;
    logic [MAG_W-1:0]        d_mag, c_mag, c_mag2;
    logic                    wide;
    logic signed [XY_W-1:0]  xs, ys, x0, y0, xr, yr, dx, dy;
    logic signed [Z_W-1:0]   zr, ta, zr4, th;

    always_comb
    begin
        d_ext  = MAG_W'(d);
        c_ext  = MAG_W'(c);
        d_mag  = d[ppaa_pkg::ACC_W-1] ? -d_ext : d_ext;
        c_mag  = c[ppaa_pkg::ACC_W-1] ? -c_ext : c_ext;
        c_mag2 = {c_mag[MAG_W-2:0], 1'b0};
        wide   = |(mx_reg[MAG_W-1:NB] | my_reg[MAG_W-1:NB]);

        xs = signed'({{(XY_W-NB){1'b0}}, mx_reg[NB-1:0]});
        ys = signed'({{(XY_W-NB){1'b0}}, my_reg[NB-1:0]});
        x0 = dneg_reg ? -xs : xs;
        y0 = cneg_reg ? -ys : ys;

        // Pre-rotate by a quarter turn when the x term points left
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                xr = y0;
                yr = -x0;
                zr = ppaa_pkg::HALF_PI_Z;
            end
            else
            begin
                xr = -y0;
                yr = x0;
                zr = -ppaa_pkg::HALF_PI_Z;
            end
        end
        else
        begin
            xr = x0;
            yr = y0;
            zr = '0;
        end

        dx  = y_reg >>> it_reg;
        dy  = x_reg >>> it_reg;
        ta  = ppaa_pkg::atan_lut(it_reg);
        zr4 = z_reg + Z_W'(4);
        th  = zr4 >>> 3;
    end

    always_comb
    begin
        st_next    = st_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        dneg_next  = dneg_reg;
        cneg_next  = cneg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        angle_next = angle_reg;

        unique case (st_reg)
            ppaa_pkg::ANG_IDLE:
            begin
                if (start)
                begin
                    mx_next   = d_mag;
                    my_next   = c_mag2;
                    dneg_next = d[ppaa_pkg::ACC_W-1];
                    cneg_next = c[ppaa_pkg::ACC_W-1];
                    if (d_mag == '0 && c_mag2 == '0)
                    begin
                        z_next  = '0;
                        st_next = ppaa_pkg::ANG_FINISH;
                    end
                    else
                    begin
                        st_next = ppaa_pkg::ANG_NORM;
                    end
                end
            end
            ppaa_pkg::ANG_NORM:
            begin
                // Shift both magnitudes together until they fit the CORDIC range
                if (wide)
                begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                end
                else
                begin
                    x_next  = xr;
                    y_next  = yr;
                    z_next  = zr;
                    it_next = '0;
                    st_next = ppaa_pkg::ANG_ROT;
                end
            end
            ppaa_pkg::ANG_ROT:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + ta;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - ta;
                end
                if (it_reg == ppaa_pkg::ITER_W'(ppaa_pkg::CORDIC_STEPS - 1))
                begin
                    st_next = ppaa_pkg::ANG_FINISH;
                end
                else
                begin
                    it_next = it_reg + 1'b1;
                end
            end
            ppaa_pkg::ANG_FINISH:
            begin
                if (th > ppaa_pkg::ANG_MAX_Z)
                begin
                    angle_next = ppaa_pkg::ANGLE_W'(ppaa_pkg::ANG_MAX_Z);
                end
                else if (th < ppaa_pkg::ANG_MIN_Z)
                begin
                    angle_next = ppaa_pkg::ANGLE_W'(ppaa_pkg::ANG_MIN_Z);
                end
                else
                begin
                    angle_next = ppaa_pkg::ANGLE_W'(th);
                end
                st_next = ppaa_pkg::ANG_IDLE;
            end
            default:
            begin
                st_next = ppaa_pkg::ANG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ppaa_pkg::ANG_IDLE;
            it_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            it_reg <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        dneg_reg  <= dneg_next;
        cneg_reg  <= cneg_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign res.done  = (st_reg == ppaa_pkg::ANG_FINISH);
    assign res.angle = angle_reg;

endmodule
